// ===== rtl/core/bas_pkg.sv =====
package bas_pkg;

  // Fixed field widths
  localparam int DATA_W     = 64;
  localparam int NIB_W      = 4;
  localparam int OP_W       = 2;

  // Default and largest number of digits in an operand
  localparam int DIGITS_DEF = 16;

  // Digits per carry lookahead group
  localparam int GRP_DIGITS = 4;

  // Operation codes; the unused code behaves as compare
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_CMP = 2'd2;

  localparam logic [NIB_W-1:0] DEC_MAX = 4'd9;
  localparam logic [NIB_W:0]   DEC_TEN = 5'd10;

endpackage

// ===== rtl/core/bcd_add_sub_compare.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | op, operand_a, operand_b
// out     | output    | out_valid/out_stall | result, carry_out, equal, greater,
//         |           |                     | less, a_zero, invalid_digit
//
// Three register stages: per-digit sums and compares, in-group carry prefixes,
// then group carries, digit correction and flags into the output register.
// One beat is accepted per cycle while in_stall is low.
// rst clears the stage valid bits only.
// A stalled output holds; stages behind it keep filling until each is full,
// so bubbles collapse before the input stalls.
module bcd_add_sub_compare #(
  parameter int DIGITS = bas_pkg::DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bas_pkg::OP_W-1:0]   op,
  input  logic [bas_pkg::DATA_W-1:0] operand_a,
  input  logic [bas_pkg::DATA_W-1:0] operand_b,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bas_pkg::DATA_W-1:0] result,
  output logic                       carry_out,
  output logic                       equal,
  output logic                       greater,
  output logic                       less,
  output logic                       a_zero,
  output logic                       invalid_digit
);
  import bas_pkg::*;

  localparam int GROUPS = (DIGITS + GRP_DIGITS - 1) / GRP_DIGITS;

  // Stage valid bits and ready chain
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3 || !out_stall;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // ---------------- Stage 1: per-digit work ----------------
  logic [OP_W-1:0]  s1_op;
  logic [NIB_W:0]   s1_sum [DIGITS];
  logic [DIGITS-1:0] s1_gen, s1_prop, s1_gt, s1_lt;
  logic             s1_bad, s1_azero;

  logic [NIB_W:0]   s1_sum_next [DIGITS];
  logic [DIGITS-1:0] s1_gen_next, s1_prop_next, s1_gt_next, s1_lt_next;
  logic             s1_bad_next, s1_azero_next;

  // Add b, or its nine's complement for subtract
  always_comb begin
    logic [NIB_W-1:0] an, bn, bx;
    s1_bad_next   = 1'b0;
    s1_azero_next = 1'b1;
    for (int j = 0; j < DIGITS; j++) begin
      an = operand_a[NIB_W*j +: NIB_W];
      bn = operand_b[NIB_W*j +: NIB_W];
      bx = (op == OP_SUB) ? (DEC_MAX - bn) : bn;
      s1_sum_next[j]  = {1'b0, an} + {1'b0, bx};
      s1_gen_next[j]  = (s1_sum_next[j] >= DEC_TEN);
      s1_prop_next[j] = (s1_sum_next[j] == {1'b0, DEC_MAX});
      s1_gt_next[j]   = (an > bn);
      s1_lt_next[j]   = (an < bn);
      if (an > DEC_MAX || bn > DEC_MAX) s1_bad_next = 1'b1;
      if (an != '0) s1_azero_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_op    <= op;
      s1_sum   <= s1_sum_next;
      s1_gen   <= s1_gen_next;
      s1_prop  <= s1_prop_next;
      s1_gt    <= s1_gt_next;
      s1_lt    <= s1_lt_next;
      s1_bad   <= s1_bad_next;
      s1_azero <= s1_azero_next;
    end
  end

  // ---------------- Stage 2: in-group prefixes ----------------
  logic [OP_W-1:0]   s2_op;
  logic [NIB_W:0]    s2_sum [DIGITS];
  logic [DIGITS-1:0] s2_cog, s2_cop;
  logic [GROUPS-1:0] s2_gt, s2_lt;
  logic              s2_bad, s2_azero;

  logic [DIGITS-1:0] s2_cog_next, s2_cop_next;
  logic [GROUPS-1:0] s2_gt_next, s2_lt_next;

  // Carry generate/propagate prefix and top-down compare inside each group
  always_comb begin
    logic gg, gp, cg, cl;
    for (int k = 0; k < GROUPS; k++) begin
      gg = 1'b0;
      gp = 1'b1;
      cg = 1'b0;
      cl = 1'b0;
      for (int m = 0; m < GRP_DIGITS; m++) begin
        if (k * GRP_DIGITS + m < DIGITS) begin
          gg = s1_gen[k*GRP_DIGITS+m] || (s1_prop[k*GRP_DIGITS+m] && gg);
          gp = gp && s1_prop[k*GRP_DIGITS+m];
          s2_cog_next[k*GRP_DIGITS+m] = gg;
          s2_cop_next[k*GRP_DIGITS+m] = gp;
          // higher digit overrides
          if (s1_gt[k*GRP_DIGITS+m] || s1_lt[k*GRP_DIGITS+m]) begin
            cg = s1_gt[k*GRP_DIGITS+m];
            cl = s1_lt[k*GRP_DIGITS+m];
          end
        end
      end
      s2_gt_next[k] = cg;
      s2_lt_next[k] = cl;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_op    <= s1_op;
      s2_sum   <= s1_sum;
      s2_cog   <= s2_cog_next;
      s2_cop   <= s2_cop_next;
      s2_gt    <= s2_gt_next;
      s2_lt    <= s2_lt_next;
      s2_bad   <= s1_bad;
      s2_azero <= s1_azero;
    end
  end

  // ---------------- Stage 3: group carries, correction, flags ----------------
  logic [GROUPS-1:0]  cin;
  logic [DATA_W-1:0]  res_next;
  logic               cy_next, gt_next, lt_next, arith, top_c;

  // Ripple carry across groups
  always_comb begin
    cin[0] = (s2_op == OP_SUB);
    for (int k = 1; k < GROUPS; k++) begin
      cin[k] = s2_cog[k*GRP_DIGITS-1] || (s2_cop[k*GRP_DIGITS-1] && cin[k-1]);
    end
    top_c = s2_cog[DIGITS-1] || (s2_cop[DIGITS-1] && cin[GROUPS-1]);
  end

  // Add carry into each digit and fold back into 0..9
  always_comb begin
    logic         c;
    logic [NIB_W:0] t;
    res_next = '0;
    for (int j = 0; j < DIGITS; j++) begin
      if (j % GRP_DIGITS == 0) begin
        c = cin[j/GRP_DIGITS];
      end else begin
        c = s2_cog[j-1] || (s2_cop[j-1] && cin[j/GRP_DIGITS]);
      end
      t = s2_sum[j] + {{NIB_W{1'b0}}, c};
      if (t >= DEC_TEN) t = t - DEC_TEN;
      res_next[NIB_W*j +: NIB_W] = t[NIB_W-1:0];
    end
  end

  // Select per operation; a bad digit zeroes the arithmetic
  always_comb begin
    case (s2_op)
      OP_ADD:  begin arith = 1'b1; cy_next = top_c;  end
      OP_SUB:  begin arith = 1'b1; cy_next = !top_c; end
      default: begin arith = 1'b0; cy_next = 1'b0;   end
    endcase
    if (!arith || s2_bad) cy_next = 1'b0;
  end

  // Compare across groups, higher group overrides
  always_comb begin
    gt_next = 1'b0;
    lt_next = 1'b0;
    for (int k = 0; k < GROUPS; k++) begin
      if (s2_gt[k] || s2_lt[k]) begin
        gt_next = s2_gt[k];
        lt_next = s2_lt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      result        <= (arith && !s2_bad) ? res_next : '0;
      carry_out     <= cy_next;
      equal         <= !gt_next && !lt_next;
      greater       <= gt_next;
      less          <= lt_next;
      a_zero        <= s2_azero;
      invalid_digit <= s2_bad;
    end
  end

endmodule

// ===== rtl/core/bas_checker.sv =====
module bas_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [bas_pkg::DATA_W-1:0] result,
  input logic                       carry_out,
  input logic                       equal,
  input logic                       greater,
  input logic                       less,
  input logic                       a_zero,
  input logic                       invalid_digit
);
  import bas_pkg::*;

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(result) && $stable(carry_out) && $stable(equal))
    else $error("stalled output beat changed");

  // Exactly one compare outcome per beat
  a_cmp_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({equal, greater, less}))
    else $error("compare flags not one-hot");

  // Bad digit zeroes the arithmetic
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid_digit |-> result == '0 && !carry_out)
    else $error("invalid digit left a nonzero result");

  // Zero a cannot exceed b
  a_zero_gt: assert property (@(posedge clk) disable iff (rst)
    out_valid && a_zero |-> !greater)
    else $error("zero operand_a compared greater");

endmodule

bind bcd_add_sub_compare bas_checker u_bas_checker (.*);

// ===== bench/bcd_arith_checker.sv =====
`timescale 1ns / 1ps

module bcd_arith_checker #(
  parameter int DIGITS = bas_pkg::DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [bas_pkg::OP_W-1:0]   op,
  input  logic [bas_pkg::DATA_W-1:0] operand_a,
  input  logic [bas_pkg::DATA_W-1:0] operand_b,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [bas_pkg::DATA_W-1:0] result,
  input  logic                       carry_out,
  input  logic                       equal,
  input  logic                       greater,
  input  logic                       less,
  input  logic                       a_zero,
  input  logic                       invalid_digit,
  output int                         mismatches,
  output int                         outstanding
);
  import bas_pkg::*;

  // Digits actually examined; nibbles above this are ignored
  localparam int NDIG = DIGITS > 16 ? 16 : (DIGITS < 1 ? 1 : DIGITS);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              carry;
    logic              eq;
    logic              gt;
    logic              lt;
    logic              a_is_zero;
    logic              bad_digit;
  } bcd_outcome_t;

  bcd_outcome_t awaited_q[$];
  int           mism_cnt = 0;

  // Decimal add/subtract/compare of one beat
  function automatic bcd_outcome_t predict_bcd(input logic [OP_W-1:0] opc,
                                               input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
    bcd_outcome_t r;
    logic [NIB_W-1:0] da, db;
    logic [NIB_W:0]   sum;
    int               diff;
    int               i;
    logic             chain;
    r           = '0;
    r.a_is_zero = 1'b1;
    chain       = 1'b0;

    // Validity and zero test over the examined digits
    for (i = 0; i < NDIG; i++) begin
      da = a[NIB_W*i +: NIB_W];
      db = b[NIB_W*i +: NIB_W];
      if (da > DEC_MAX || db > DEC_MAX) r.bad_digit = 1'b1;
      if (da != '0) r.a_is_zero = 1'b0;
    end

    // Magnitude compare from the top digit down, raw nibble values
    for (i = NDIG - 1; i >= 0; i--) begin
      da = a[NIB_W*i +: NIB_W];
      db = b[NIB_W*i +: NIB_W];
      if (da != db) begin
        r.gt = da > db;
        r.lt = da < db;
        break;
      end
    end
    r.eq = !r.gt && !r.lt;

    // Ripple the decimal carry or borrow
    if (opc == OP_ADD) begin
      for (i = 0; i < NDIG; i++) begin
        sum = {1'b0, a[NIB_W*i +: NIB_W]} + {1'b0, b[NIB_W*i +: NIB_W]}
              + {{NIB_W{1'b0}}, chain};
        chain = sum >= DEC_TEN;
        if (chain) sum = sum - DEC_TEN;
        r.value[NIB_W*i +: NIB_W] = sum[NIB_W-1:0];
      end
    end else if (opc == OP_SUB) begin
      for (i = 0; i < NDIG; i++) begin
        diff = int'(a[NIB_W*i +: NIB_W]) - int'(b[NIB_W*i +: NIB_W]) - int'(chain);
        chain = diff < 0;
        if (chain) diff = diff + int'(DEC_TEN);
        r.value[NIB_W*i +: NIB_W] = diff[NIB_W-1:0];
      end
    end

    // Drop the arithmetic when a digit is out of range
    if (r.bad_digit) begin
      r.value = '0;
      chain   = 1'b0;
    end
    r.carry = chain;
    return r;
  endfunction

  // Queue predictions on accepted input beats, match output beats in order
  always @(posedge clk) begin : watch
    bcd_outcome_t want, got;
    if (!rst) begin
      if (in_valid && !in_stall) awaited_q.push_back(predict_bcd(op, operand_a, operand_b));
      if (out_valid && !out_stall) begin
        got = {result, carry_out, equal, greater, less, a_zero, invalid_digit};
        if (awaited_q.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("%0t: unexpected output beat res=%h co=%b eq=%b gt=%b lt=%b az=%b inv=%b",
                     $time, got.value, got.carry, got.eq, got.gt, got.lt, got.a_is_zero,
                     got.bad_digit);
        end else begin
          want = awaited_q.pop_front();
          if (got !== want) begin
            mism_cnt++;
            if (mism_cnt <= 10) begin
              $display("%0t: expected res=%h co=%b eq=%b gt=%b lt=%b az=%b inv=%b",
                       $time, want.value, want.carry, want.eq, want.gt, want.lt,
                       want.a_is_zero, want.bad_digit);
              $display("%0t:   actual res=%h co=%b eq=%b gt=%b lt=%b az=%b inv=%b",
                       $time, got.value, got.carry, got.eq, got.gt, got.lt,
                       got.a_is_zero, got.bad_digit);
            end
          end
        end
      end
    end
    mismatches  <= mism_cnt;
    outstanding <= awaited_q.size();
  end

endmodule

// ===== bench/tb_bcd_add_sub_compare.sv =====
`timescale 1ns / 1ps

module tb_bcd_add_sub_compare;
  import bas_pkg::*;

  // Unused op code, expected to act as compare
  localparam logic [OP_W-1:0]   OP_RSVD   = 2'd3;
  localparam logic [DATA_W-1:0] ALL_NINES = 64'h9999_9999_9999_9999;
  localparam logic [DATA_W-1:0] ALL_ONES  = '1;
  localparam int                RAND_BEATS = 450;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   op        = OP_ADD;
  logic [DATA_W-1:0] operand_a = '0;
  logic [DATA_W-1:0] operand_b = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] result;
  logic              carry_out;
  logic              equal;
  logic              greater;
  logic              less;
  logic              a_zero;
  logic              invalid_digit;
  logic              idle_en   = 1'b0;
  int                mismatches;
  int                outstanding;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bcd_add_sub_compare i_dut (.*);

  bcd_arith_checker i_checker (.*);

  // Random packed BCD number with the given number of low digits
  function automatic logic [DATA_W-1:0] bcd_number(input int ndig);
    logic [DATA_W-1:0] v;
    v = '0;
    for (int i = 0; i < ndig; i++) v[NIB_W*i +: NIB_W] = NIB_W'($urandom_range(0, 9));
    return v;
  endfunction

  // Mostly full width, sometimes shorter numbers
  function automatic int digit_count();
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 16);
    return 16;
  endfunction

  // Present one beat, optionally after an idle burst, and hold until taken
  task automatic drive_beat(input logic [OP_W-1:0] o, input logic [DATA_W-1:0] a,
                            input logic [DATA_W-1:0] b);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= o;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off the sender until every queued result is out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Receiver stall bursts
  initial begin : stall_gen
    int n;
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [DATA_W-1:0] a, b;
    logic [OP_W-1:0]   o;
    int                kind;
    int                pos;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every op, carries, borrows, bad digits
    drive_beat(OP_ADD, '0, '0);
    drive_beat(OP_ADD, ALL_NINES, 64'h1);
    drive_beat(OP_ADD, ALL_NINES, ALL_NINES);
    drive_beat(OP_ADD, 64'h5, 64'h5);
    drive_beat(OP_ADD, 64'h5000_0000_0000_0000, 64'h5000_0000_0000_0000);
    drive_beat(OP_SUB, '0, 64'h1);
    drive_beat(OP_SUB, 64'h1, '0);
    drive_beat(OP_SUB, ALL_NINES, ALL_NINES);
    drive_beat(OP_SUB, 64'h1000_0000_0000_0000, 64'h1);
    drive_beat(OP_SUB, '0, ALL_NINES);
    drive_beat(OP_SUB, 64'h1234_5678_9012_3456, 64'h6543_2109_8765_4321);
    drive_beat(OP_CMP, 64'h9000_0000_0000_0000, 64'h0999_9999_9999_9999);
    drive_beat(OP_CMP, 64'h12, 64'h13);
    drive_beat(OP_CMP, ALL_NINES, ALL_NINES);
    drive_beat(OP_RSVD, 64'h1234_5678_9012_3456, 64'h0567_8901_2345_6789);
    drive_beat(OP_RSVD, ALL_NINES, '0);
    drive_beat(OP_ADD, 64'hF000_0000_0000_0000, 64'h1);
    drive_beat(OP_SUB, 64'h5, 64'hA);
    drive_beat(OP_CMP, ALL_ONES, '0);
    drive_beat(OP_ADD, '0, ALL_ONES);
    drive_beat(OP_SUB, 64'hA, 64'h9);
    drive_beat(OP_RSVD, ALL_ONES, ALL_ONES);
    hold_until_drained();

    // Random: mostly valid BCD with some bad digits and raw noise
    for (int n = 0; n < RAND_BEATS; n++) begin
      if (n % 50 == 0) idle_en <= (n < 350) && (n / 50 != 4);
      if (n == 225) hold_until_drained();

      if ($urandom_range(0, 15) == 0) o = OP_RSVD;
      else begin
        case ($urandom_range(0, 2))
          0:       o = OP_ADD;
          1:       o = OP_SUB;
          default: o = OP_CMP;
        endcase
      end
      a    = bcd_number(digit_count());
      b    = bcd_number(digit_count());
      kind = $urandom_range(0, 19);
      pos  = $urandom_range(0, 15);

      if (kind >= 7 && kind <= 9) begin
        // near-equal: same number, maybe one digit changed
        b = a;
        if ($urandom_range(0, 2) != 0) b[NIB_W*pos +: NIB_W] = NIB_W'($urandom_range(0, 9));
      end else if (kind == 10) begin
        a = '0;
      end else if (kind == 11) begin
        b = '0;
      end else if (kind == 12) begin
        a = ALL_NINES;
      end else if (kind == 13) begin
        b = ALL_NINES;
      end else if (kind >= 14 && kind <= 16) begin
        // inject one out-of-range digit into a, b or both
        if (kind != 15) a[NIB_W*pos +: NIB_W] = NIB_W'($urandom_range(10, 15));
        if (kind != 14) b[NIB_W*$urandom_range(0, 15) +: NIB_W] = NIB_W'($urandom_range(10, 15));
      end else if (kind >= 17) begin
        a = {$urandom, $urandom};
        b = (kind == 19) ? a : {$urandom, $urandom};
      end
      drive_beat(o, a, b);
    end

    // Drain and settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("bcd_add_sub_compare: match");
    end else begin
      $display("bcd_add_sub_compare: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("bcd_add_sub_compare: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bas_pkg.sv
rtl/core/bcd_add_sub_compare.sv
rtl/core/bas_checker.sv
bench/bcd_arith_checker.sv
bench/tb_bcd_add_sub_compare.sv
